// ===== src/bbfc_pkg.sv =====
// shared types, command codes and block map for the boot-block flash command machine
package bbfc_pkg;

	localparam int MEM_BYTES = 131072;
	localparam int ADDR_W = $clog2(MEM_BYTES);

	localparam logic [7:0] CMD_READ_ARRAY    = 8'hFF;
	localparam logic [7:0] CMD_IDENTIFY      = 8'h90;
	localparam logic [7:0] CMD_READ_STATUS   = 8'h70;
	localparam logic [7:0] CMD_CLEAR_STATUS  = 8'h50;
	localparam logic [7:0] CMD_ERASE_SETUP   = 8'h20;
	localparam logic [7:0] CMD_ERASE_CONFIRM = 8'hD0;
	localparam logic [7:0] CMD_PROGRAM       = 8'h40;
	localparam logic [7:0] CMD_PROGRAM_ALT   = 8'h10;

	localparam logic [7:0] MANUFACTURER_ID = 8'h89;
	localparam logic [7:0] DEVICE_ID_RESET = 8'h94;
	localparam logic [7:0] STATUS_READY    = 8'h80;
	localparam logic [7:0] STATUS_CLEAR    = 8'h00;
	localparam logic [7:0] ERASED_BYTE     = 8'hFF;

	localparam logic [2:0] BLK_MAIN   = 3'd0;
	localparam logic [2:0] BLK_PARAM1 = 3'd4;
	localparam logic [2:0] BLK_PARAM2 = 3'd5;
	localparam logic [2:0] BLK_BOOT   = 3'd6;

	localparam logic [ADDR_W-1:0] PARAM1_BASE = 17'h1C000;
	localparam logic [ADDR_W-1:0] PARAM2_BASE = 17'h1D000;
	localparam logic [ADDR_W-1:0] BOOT_BASE   = 17'h1E000;
	localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(MEM_BYTES - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ERASE
	} bbfc_state_t;

	typedef struct packed {
		logic accept;
		logic erase_load;
		logic sweep;
	} bbfc_ctrl_t;

	typedef struct packed {
		logic erase_req;
		logic sweep_last;
	} bbfc_stat_t;

	function automatic logic [2:0] block_code(input logic [ADDR_W-1:0] a);
		logic [2:0] c;
		if (a < PARAM1_BASE) begin
			c = BLK_MAIN;
		end else if (a < PARAM2_BASE) begin
			c = BLK_PARAM1;
		end else if (a < BOOT_BASE) begin
			c = BLK_PARAM2;
		end else begin
			c = BLK_BOOT;
		end
		return c;
	endfunction

	function automatic logic [ADDR_W-1:0] block_first(input logic [2:0] c);
		logic [ADDR_W-1:0] a;
		unique case (c)
			BLK_PARAM1: a = PARAM1_BASE;
			BLK_PARAM2: a = PARAM2_BASE;
			default:    a = '0;
		endcase
		return a;
	endfunction

	function automatic logic [ADDR_W-1:0] block_last(input logic [2:0] c);
		logic [ADDR_W-1:0] a;
		unique case (c)
			BLK_PARAM1: a = PARAM2_BASE - 1'b1;
			BLK_PARAM2: a = BOOT_BASE - 1'b1;
			default:    a = PARAM1_BASE - 1'b1;
		endcase
		return a;
	endfunction

endpackage

// ===== src/bbfc_ctrl.sv =====
// controller state machine: clearing pass, idle bus service and block erase sweep
module bbfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bbfc_pkg::bbfc_stat_t stat,
	output bbfc_pkg::bbfc_ctrl_t ctrl,
	output logic                busy
);

	bbfc_pkg::bbfc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbfc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		busy = 1'b1;
		unique case (state_q)
			bbfc_pkg::ST_CLEAR, bbfc_pkg::ST_ERASE: begin
				ctrl.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = bbfc_pkg::ST_IDLE;
				end
			end
			bbfc_pkg::ST_IDLE: begin
				busy = 1'b0;
				ctrl.accept = start;
				if (start && stat.erase_req) begin
					ctrl.erase_load = 1'b1;
					state_d = bbfc_pkg::ST_ERASE;
				end
			end
			default: begin
				state_d = bbfc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/bbfc_dpath.sv =====
// datapath: command, status and target registers, flash array and read word output
module bbfc_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bbfc_pkg::bbfc_ctrl_t             ctrl,
	output bbfc_pkg::bbfc_stat_t             stat,
	input  logic                             action,
	input  logic [bbfc_pkg::ADDR_W-1:0]      address,
	input  logic [7:0]                       write_data,
	input  logic                             cfg_write_en,
	input  logic [7:0]                       cfg_write_data,
	output logic [7:0]                       read_data,
	output logic                             done
);

	logic [7:0]                  cmd_q;
	logic [7:0]                  status_q;
	logic [bbfc_pkg::ADDR_W-1:0] target_q;
	logic [7:0]                  device_id_q;
	logic [bbfc_pkg::ADDR_W-1:0] sweep_addr_q;
	logic [bbfc_pkg::ADDR_W-1:0] sweep_end_q;
	logic                        done_q;
	logic                        use_array_q;
	logic [7:0]                  alt_data_q;
	logic [7:0]                  rd_q;

	logic [7:0]                  mem [bbfc_pkg::MEM_BYTES];

	logic [2:0]                  addr_code;
	logic                        in_write;
	logic                        prog_ok;
	logic                        mem_we;
	logic [bbfc_pkg::ADDR_W-1:0] mem_addr;
	logic [7:0]                  mem_wdata;

	assign addr_code = bbfc_pkg::block_code(address);
	assign in_write  = ctrl.accept && action;

	assign prog_ok = (cmd_q == bbfc_pkg::CMD_PROGRAM || cmd_q == bbfc_pkg::CMD_PROGRAM_ALT)
		&& address == target_q && addr_code != bbfc_pkg::BLK_BOOT;

	assign stat.erase_req = action && cmd_q == bbfc_pkg::CMD_ERASE_SETUP
		&& write_data == bbfc_pkg::CMD_ERASE_CONFIRM
		&& target_q == bbfc_pkg::ADDR_W'(addr_code) && addr_code != bbfc_pkg::BLK_BOOT;
	assign stat.sweep_last = sweep_addr_q == sweep_end_q;

	assign mem_we    = ctrl.sweep || (in_write && prog_ok);
	assign mem_addr  = ctrl.sweep ? sweep_addr_q : address;
	assign mem_wdata = ctrl.sweep ? bbfc_pkg::ERASED_BYTE : write_data;

	// single-port array, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	// sweep range, covers the whole array after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			sweep_end_q  <= bbfc_pkg::LAST_ADDR;
		end else if (ctrl.erase_load) begin
			sweep_addr_q <= bbfc_pkg::block_first(addr_code);
			sweep_end_q  <= bbfc_pkg::block_last(addr_code);
		end else if (ctrl.sweep) begin
			sweep_addr_q <= sweep_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= bbfc_pkg::CMD_READ_ARRAY;
			status_q    <= bbfc_pkg::STATUS_CLEAR;
			target_q    <= '0;
			device_id_q <= bbfc_pkg::DEVICE_ID_RESET;
		end else begin
			if (cfg_write_en) begin
				device_id_q <= cfg_write_data;
			end
			if (in_write) begin
				unique case (cmd_q)
					bbfc_pkg::CMD_ERASE_SETUP: begin
						if (write_data == bbfc_pkg::CMD_ERASE_CONFIRM) begin
							status_q <= bbfc_pkg::STATUS_READY;
						end
						cmd_q <= bbfc_pkg::CMD_READ_STATUS;
					end
					bbfc_pkg::CMD_PROGRAM, bbfc_pkg::CMD_PROGRAM_ALT: begin
						status_q <= bbfc_pkg::STATUS_READY;
						cmd_q    <= bbfc_pkg::CMD_READ_STATUS;
					end
					default: begin
						cmd_q <= write_data;
						if (write_data == bbfc_pkg::CMD_CLEAR_STATUS) begin
							status_q <= bbfc_pkg::STATUS_CLEAR;
						end else if (write_data == bbfc_pkg::CMD_ERASE_SETUP) begin
							target_q <= bbfc_pkg::ADDR_W'(addr_code);
						end else if (write_data == bbfc_pkg::CMD_PROGRAM
								|| write_data == bbfc_pkg::CMD_PROGRAM_ALT) begin
							target_q <= address;
						end
					end
				endcase
			end
		end
	end

	// read word select, lined up with the registered array data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.accept && !action;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			use_array_q <= 1'b0;
			if (cmd_q == bbfc_pkg::CMD_IDENTIFY) begin
				alt_data_q <= address[0] ? device_id_q : bbfc_pkg::MANUFACTURER_ID;
			end else if (cmd_q == bbfc_pkg::CMD_READ_STATUS) begin
				alt_data_q <= status_q;
			end else begin
				alt_data_q  <= bbfc_pkg::ERASED_BYTE;
				use_array_q <= 1'b1;
			end
		end
	end

	assign read_data = use_array_q ? rd_q : alt_data_q;
	assign done      = done_q;

endmodule

// ===== src/boot_block_flash_command_machine.sv =====
// top level of the boot-block flash command machine
//
//  channel   handshake                 payload
//  bus in    start / busy              action, address, write_data
//  result    done (one-cycle strobe)   read_data
//  config    cfg_write_en              cfg_write_data (device_id)
//
// one bus word per cycle while idle; a read word appears with done in the cycle after acceptance
// writes take effect at the acceptance edge and return no word
// block erase holds busy while the array port sweeps the block: 4096 bytes for a
// parameter block, 114688 for the main block
// after reset the array port clears all 131072 bytes, with busy held high meanwhile
// the receiver cannot stall; done is never held
module boot_block_flash_command_machine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        action,
	input  logic [bbfc_pkg::ADDR_W-1:0] address,
	input  logic [7:0]                  write_data,
	input  logic                        cfg_write_en,
	input  logic [7:0]                  cfg_write_data,
	output logic                        done,
	output logic [7:0]                  read_data
);

	bbfc_pkg::bbfc_ctrl_t ctrl;
	bbfc_pkg::bbfc_stat_t stat;

	bbfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	bbfc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.action         (action),
		.address        (address),
		.write_data     (write_data),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.read_data      (read_data),
		.done           (done)
	);

`ifndef SYNTHESIS
	a_read_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !action) |=> done)
		else $error("accepted read gave no word");

	a_erase_holds_bus: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.erase_load |=> (busy && !done))
		else $error("erase start did not hold the bus");

	a_no_word_while_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.sweep |-> (!ctrl.accept && !ctrl.erase_load))
		else $error("bus word taken during array sweep");
`endif

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the boot-block flash command machine: directed and random bus traffic
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbfc_pkg::*;

	localparam logic ACT_READ = 1'b0;
	localparam logic ACT_WRITE = 1'b1;
	localparam logic [7:0] CMD_UNKNOWN = 8'h33;
	localparam int STALL_LIMIT = 400000;
	localparam int PHASE_WORDS = 150;
	localparam int PHASES = 6;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic action;
	logic [ADDR_W-1:0] address;
	logic [7:0] write_data;
	logic cfg_write_en;
	logic [7:0] cfg_write_data;
	logic done;
	logic [7:0] read_data;

	logic [7:0] flash_mem [MEM_BYTES];
	logic [7:0] cmd_latch;
	logic [7:0] status_reg;
	logic [ADDR_W-1:0] target_reg;
	logic [7:0] id_reg;
	logic [7:0] expected_bytes [$];
	logic [ADDR_W-1:0] hot_addr [8];
	logic [7:0] want_byte;
	bit steady;
	int words_sent;
	int errors;
	int idle_cycles;

	boot_block_flash_command_machine dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.address(address),
		.write_data(write_data),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.done(done),
		.read_data(read_data)
	);

	always #4 clk = ~clk;

	function automatic logic [2:0] region_of(input logic [ADDR_W-1:0] a);
		if (a >= BOOT_BASE) return BLK_BOOT;
		if (a >= PARAM2_BASE) return BLK_PARAM2;
		if (a >= PARAM1_BASE) return BLK_PARAM1;
		return BLK_MAIN;
	endfunction

	function automatic void erase_model(input logic [2:0] code);
		int lo;
		int hi;
		case (code)
			BLK_MAIN: begin
				lo = 0;
				hi = int'(PARAM1_BASE) - 1;
			end
			BLK_PARAM1: begin
				lo = int'(PARAM1_BASE);
				hi = int'(PARAM2_BASE) - 1;
			end
			BLK_PARAM2: begin
				lo = int'(PARAM2_BASE);
				hi = int'(BOOT_BASE) - 1;
			end
			default: return;
		endcase
		for (int a = lo; a <= hi; a++) flash_mem[a] = ERASED_BYTE;
	endfunction

	function automatic void model_reset();
		foreach (flash_mem[i]) flash_mem[i] = ERASED_BYTE;
		cmd_latch = CMD_READ_ARRAY;
		status_reg = STATUS_CLEAR;
		target_reg = '0;
		id_reg = DEVICE_ID_RESET;
		foreach (hot_addr[i]) hot_addr[i] = '0;
	endfunction

	// advance the flash model by one accepted bus word
	function automatic void predict_word(input logic act, input logic [ADDR_W-1:0] a,
			input logic [7:0] d);
		logic [2:0] code;
		code = region_of(a);
		if (act == ACT_READ) begin
			if (cmd_latch == CMD_IDENTIFY) expected_bytes.push_back(a[0] ? id_reg : MANUFACTURER_ID);
			else if (cmd_latch == CMD_READ_STATUS) expected_bytes.push_back(status_reg);
			else expected_bytes.push_back(flash_mem[a]);
			return;
		end
		case (cmd_latch)
			CMD_ERASE_SETUP: begin
				if (d == CMD_ERASE_CONFIRM) begin
					if (ADDR_W'(code) == target_reg && code != BLK_BOOT) erase_model(code);
					status_reg = STATUS_READY;
				end
				cmd_latch = CMD_READ_STATUS;
			end
			CMD_PROGRAM, CMD_PROGRAM_ALT: begin
				if (a == target_reg && code != BLK_BOOT) flash_mem[a] = d;
				cmd_latch = CMD_READ_STATUS;
				status_reg = STATUS_READY;
			end
			default: begin
				cmd_latch = d;
				if (d == CMD_CLEAR_STATUS) status_reg = STATUS_CLEAR;
				else if (d == CMD_ERASE_SETUP) target_reg = ADDR_W'(code);
				else if (d == CMD_PROGRAM || d == CMD_PROGRAM_ALT) target_reg = a;
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'($urandom());
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("tb: mismatch at %0t: %s, got %02h, want %02h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_word(input logic act, input logic [ADDR_W-1:0] a, input logic [7:0] d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		address <= a;
		write_data <= d;
		do @(posedge clk); while (busy !== 1'b0);
		predict_word(act, a, d);
		words_sent++;
	endtask

	task automatic read_word(input logic [ADDR_W-1:0] a);
		send_word(ACT_READ, a, 8'($urandom()));
	endtask

	task automatic write_word(input logic [ADDR_W-1:0] a, input logic [7:0] d);
		send_word(ACT_WRITE, a, d);
	endtask

	// bus quiet until every read word is back and no erase is running
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (expected_bytes.size() != 0);
		repeat (3) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_device_id(input logic [7:0] v);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		id_reg = v;
	endtask

	task automatic test_identify();
		write_word(rand_addr(), CMD_IDENTIFY);
		read_word('0);
		read_word(LAST_ADDR);
	endtask

	task automatic test_program();
		write_word('0, CMD_PROGRAM);
		write_word('0, 8'h00);
		read_word(rand_addr());
		write_word('0, CMD_READ_ARRAY);
		read_word('0);
		write_word(BOOT_BASE - 1'b1, CMD_PROGRAM_ALT);
		write_word(BOOT_BASE - 1'b1, 8'h5A);
		write_word(LAST_ADDR, CMD_PROGRAM);
		write_word(LAST_ADDR, 8'h12);
	endtask

	task automatic test_status();
		write_word(rand_addr(), CMD_CLEAR_STATUS);
		write_word(rand_addr(), CMD_READ_STATUS);
		read_word(rand_addr());
		write_word(rand_addr(), CMD_UNKNOWN);
		read_word(BOOT_BASE - 1'b1);
	endtask

	task automatic test_erase();
		write_word(PARAM1_BASE, CMD_ERASE_SETUP);
		write_word(PARAM1_BASE, 8'h11);
		read_word(rand_addr());
		write_word(PARAM2_BASE, CMD_ERASE_SETUP);
		write_word(BOOT_BASE - 1'b1, CMD_ERASE_CONFIRM);
		write_word(BOOT_BASE, CMD_ERASE_SETUP);
		write_word(LAST_ADDR, CMD_ERASE_CONFIRM);
		write_word(17'h01234, CMD_ERASE_SETUP);
		write_word('0, CMD_ERASE_CONFIRM);
		write_word('0, CMD_READ_ARRAY);
		read_word('0);
		read_word(BOOT_BASE - 1'b1);
	endtask

	task automatic program_seq();
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		a = ($urandom_range(0, 9) != 0) ? ADDR_W'($urandom_range(0, BOOT_BASE - 1)) : rand_addr();
		b = ($urandom_range(0, 7) != 0) ? a : rand_addr();
		write_word(a, $urandom_range(0, 1) ? CMD_PROGRAM : CMD_PROGRAM_ALT);
		write_word(b, 8'($urandom()));
		hot_addr[$urandom_range(0, 7)] = a;
		if ($urandom_range(0, 1)) read_word(a);
		write_word(a, CMD_READ_ARRAY);
		read_word(a);
	endtask

	task automatic erase_seq();
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] a;
		int span;
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			base = PARAM1_BASE;
			span = int'(PARAM2_BASE - PARAM1_BASE);
		end else if (r < 9) begin
			base = PARAM2_BASE;
			span = int'(BOOT_BASE - PARAM2_BASE);
		end else begin
			base = BOOT_BASE;
			span = MEM_BYTES - int'(BOOT_BASE);
		end
		write_word(base + ADDR_W'($urandom_range(0, span - 1)), CMD_ERASE_SETUP);
		a = ($urandom_range(0, 6) != 0) ? base + ADDR_W'($urandom_range(0, span - 1))
			: rand_addr();
		write_word(a, ($urandom_range(0, 9) != 0) ? CMD_ERASE_CONFIRM : 8'($urandom()));
		read_word(a);
		write_word(a, CMD_READ_ARRAY);
		read_word(a);
	endtask

	task automatic test_random_traffic();
		logic [7:0] id_value;
		int goal;
		int r;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: id_value = 8'h00;
				1: id_value = 8'hFF;
				default: id_value = 8'($urandom());
			endcase
			settle();
			set_device_id(id_value);
			goal = words_sent + PHASE_WORDS;
			while (words_sent < goal) begin
				steady = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 2) begin
					settle();
				end else if (r < 32) begin
					program_seq();
				end else if (r < 40) begin
					erase_seq();
				end else if (r < 50) begin
					write_word(rand_addr(), CMD_IDENTIFY);
					repeat ($urandom_range(1, 4)) read_word(rand_addr());
					if ($urandom_range(0, 1)) write_word(rand_addr(), CMD_READ_ARRAY);
				end else if (r < 58) begin
					if ($urandom_range(0, 1)) write_word(rand_addr(), CMD_CLEAR_STATUS);
					write_word(rand_addr(), CMD_READ_STATUS);
					repeat ($urandom_range(1, 2)) read_word(rand_addr());
				end else if (r < 72) begin
					write_word(rand_addr(), CMD_READ_ARRAY);
					repeat ($urandom_range(1, 6))
						read_word($urandom_range(0, 1) ? hot_addr[$urandom_range(0, 7)]
							: rand_addr());
				end else begin
					repeat ($urandom_range(1, 4))
						send_word(1'($urandom()), rand_addr(), 8'($urandom()));
				end
			end
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("read word with none pending", read_data, 8'h00);
			end else begin
				want_byte = expected_bytes.pop_front();
				if (read_data !== want_byte) report_mismatch("read_data", read_data, want_byte);
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			idle_cycles = 0;
		end else if (++idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_READ;
		address <= '0;
		write_data <= '0;
		cfg_write_en <= 1'b0;
		cfg_write_data <= '0;
		steady = 1'b0;
		words_sent = 0;
		errors = 0;
		idle_cycles = 0;
		model_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		settle();
		test_identify();
		test_program();
		test_status();
		test_erase();
		test_random_traffic();
		settle();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/bbfc_pkg.sv
src/bbfc_ctrl.sv
src/bbfc_dpath.sv
src/boot_block_flash_command_machine.sv
bench/tb.sv
